>>> rtl/tmw_pkg.sv
// Package for the text-mode terminal writer.
// Holds the screen geometry, operation and character codes, and the
// command and status types shared by the controller and the datapath.
package tmw_pkg;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELL_COUNT   = COLUMNS * ROWS;
  localparam int SCROLL_CELLS = COLUMNS * (ROWS - 1);
  localparam int COL_W        = $clog2(COLUMNS);
  localparam int ROW_W        = $clog2(ROWS);
  localparam int ADDR_W       = $clog2(CELL_COUNT);

  localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
  localparam logic [2:0] OP_SET_CURSOR = 3'd1;
  localparam logic [2:0] OP_PUT_CELL   = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_READ_CELL  = 3'd4;

  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [15:0]       cell_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic init_wr;
    logic fill_wr;
    logic copy_rd;
    logic copy_wr;
    logic idx_clr;
    logic idx_blank;
    logic idx_inc;
    logic out_load;
  } tmw_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       scroll_need;
    logic       idx_last;
    logic       copy_last;
    logic       out_free;
  } tmw_stat_t;

  function automatic addr_t cell_addr(input logic [6:0] col, input logic [5:0] row);
    return ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

  function automatic logic [10:0] lin11(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
    return 11'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

>>> rtl/tmw_in_if.sv
// Input channel of the terminal writer: valid, ready and one command item.
// Field widths are fixed by the item format; depends on nothing else.
interface tmw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] char_code;
  logic [6:0] pos_x;
  logic [5:0] pos_y;
  logic [7:0] cell_color;

  modport source(output valid, operation, char_code, pos_x, pos_y, cell_color,
                 input ready);
  modport sink(input valid, operation, char_code, pos_x, pos_y, cell_color,
               output ready);
endinterface

>>> rtl/tmw_out_if.sv
// Result channel of the terminal writer: valid, ready and one result item.
// Field widths are fixed by the result format; depends on nothing else.
interface tmw_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_linear;
  logic        did_scroll;
  logic [7:0]  read_char;
  logic [7:0]  read_attr;

  modport source(output valid, cursor_col, cursor_row, cursor_linear, did_scroll,
                 read_char, read_attr, input ready);
  modport sink(input valid, cursor_col, cursor_row, cursor_linear, did_scroll,
               read_char, read_attr, output ready);
endinterface

>>> rtl/tmw_ctrl.sv
// Controller state machine of the terminal writer.
// Sequences item decode, store sweeps and result transfer; uses tmw_pkg.
module tmw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tmw_pkg::tmw_stat_t stat,
  output tmw_pkg::tmw_cmd_t  cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_RDWAIT = 4'd3;
  localparam logic [3:0] S_SC_RD  = 4'd4;
  localparam logic [3:0] S_SC_WR  = 4'd5;
  localparam logic [3:0] S_BLANK  = 4'd6;
  localparam logic [3:0] S_CLEAR  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.op == tmw_pkg::OP_PUT_CHAR && stat.scroll_need) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SC_RD;
        end else if (stat.op == tmw_pkg::OP_CLEAR) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CLEAR;
        end else if (stat.op == tmw_pkg::OP_READ_CELL) begin
          state_nxt = S_RDWAIT;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDWAIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SC_RD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.copy_wr = 1'b1;
        if (stat.copy_last) begin
          cmd.idx_blank = 1'b1;
          state_nxt     = S_BLANK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SC_RD;
        end
      end
      S_BLANK, S_CLEAR: begin
        cmd.fill_wr = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/tmw_dp.sv
// Datapath of the terminal writer: cell store, cursor, attribute register,
// sweep counter and result register. Driven by tmw_ctrl; uses tmw_pkg.
module tmw_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic [2:0]         in_operation,
  input  logic [7:0]         in_char_code,
  input  logic [6:0]         in_pos_x,
  input  logic [5:0]         in_pos_y,
  input  logic [7:0]         in_cell_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_cursor_col,
  output logic [4:0]         out_cursor_row,
  output logic [10:0]        out_cursor_linear,
  output logic               out_did_scroll,
  output logic [7:0]         out_read_char,
  output logic [7:0]         out_read_attr,
  input  tmw_pkg::tmw_cmd_t  cmd,
  output tmw_pkg::tmw_stat_t stat
);

  localparam int COL_W  = tmw_pkg::COL_W;
  localparam int ROW_W  = tmw_pkg::ROW_W;
  localparam int ADDR_W = tmw_pkg::ADDR_W;
  localparam int CW1    = COL_W + 1;

  logic [2:0]       op_r;
  logic [7:0]       ch_r;
  logic [6:0]       px_r;
  logic [5:0]       py_r;
  logic [7:0]       color_r;
  logic [7:0]       attr_r;
  logic [COL_W-1:0] cur_col_r;
  logic [ROW_W-1:0] cur_row_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;
  tmw_pkg::addr_t   idx_r;
  logic             scroll_r;
  logic             scroll_nxt;
  logic             rd_hit_r;
  logic             rd_hit_nxt;
  logic             out_valid_r;

  logic [6:0]       out_col_r;
  logic [4:0]       out_row_r;
  logic [10:0]      out_lin_r;
  logic             out_scroll_r;
  logic [7:0]       out_char_r;
  logic [7:0]       out_attr_r;

  tmw_pkg::cell_t   mem [tmw_pkg::CELL_COUNT];
  tmw_pkg::cell_t   rdata_r;
  logic             we;
  tmw_pkg::addr_t   waddr;
  tmw_pkg::cell_t   wdata;
  logic             re;
  tmw_pkg::addr_t   raddr;

  logic [CW1-1:0]   col_p1;
  logic [CW1-1:0]   col_tab;
  logic [COL_W-1:0] put_col;
  logic [ROW_W-1:0] put_row;
  logic             put_we;
  tmw_pkg::addr_t   put_addr;
  tmw_pkg::cell_t   put_data;
  logic             put_adv;
  logic             scroll_need;
  logic             pos_ok;
  logic             exec_we;
  tmw_pkg::addr_t   exec_addr;
  tmw_pkg::cell_t   exec_data;

  assign col_p1  = {1'b0, cur_col_r} + CW1'(1);
  assign col_tab = ({1'b0, cur_col_r} + CW1'(8)) & ~CW1'(7);
  assign pos_ok  = (int'(px_r) < tmw_pkg::COLUMNS) && (int'(py_r) < tmw_pkg::ROWS);

  always_comb begin
    put_col     = cur_col_r;
    put_row     = cur_row_r;
    put_we      = 1'b0;
    put_addr    = tmw_pkg::cell_addr(7'(cur_col_r), 6'(cur_row_r));
    put_data    = {attr_r, ch_r};
    put_adv     = 1'b0;
    scroll_need = 1'b0;
    case (ch_r)
      tmw_pkg::CH_LF: begin
        put_col = '0;
        put_adv = 1'b1;
      end
      tmw_pkg::CH_CR: begin
        put_col = '0;
      end
      tmw_pkg::CH_TAB: begin
        if (col_tab >= CW1'(tmw_pkg::COLUMNS)) begin
          put_col = '0;
          put_adv = 1'b1;
        end else begin
          put_col = COL_W'(col_tab);
        end
      end
      tmw_pkg::CH_BS: begin
        if (cur_col_r != '0) begin
          put_col  = cur_col_r - COL_W'(1);
          put_we   = 1'b1;
          put_addr = tmw_pkg::cell_addr(7'(cur_col_r - COL_W'(1)), 6'(cur_row_r));
          put_data = {attr_r, tmw_pkg::CH_SPACE};
        end
      end
      default: begin
        if (ch_r >= tmw_pkg::CH_SPACE) begin
          put_we = 1'b1;
          if (col_p1 >= CW1'(tmw_pkg::COLUMNS)) begin
            put_col = '0;
            put_adv = 1'b1;
          end else begin
            put_col = COL_W'(col_p1);
          end
        end
      end
    endcase
    if (put_adv) begin
      if (cur_row_r == ROW_W'(tmw_pkg::ROWS - 1)) begin
        scroll_need = 1'b1;
      end else begin
        put_row = cur_row_r + ROW_W'(1);
      end
    end
  end

  always_comb begin
    col_nxt    = cur_col_r;
    row_nxt    = cur_row_r;
    scroll_nxt = scroll_r;
    rd_hit_nxt = rd_hit_r;
    exec_we    = 1'b0;
    exec_addr  = put_addr;
    exec_data  = put_data;
    if (cmd.exec) begin
      case (op_r)
        tmw_pkg::OP_PUT_CHAR: begin
          col_nxt    = put_col;
          row_nxt    = put_row;
          scroll_nxt = scroll_need;
          exec_we    = put_we;
        end
        tmw_pkg::OP_SET_CURSOR: begin
          if (int'(px_r) < tmw_pkg::COLUMNS) begin
            col_nxt = COL_W'(px_r);
          end
          if (int'(py_r) < tmw_pkg::ROWS) begin
            row_nxt = ROW_W'(py_r);
          end
        end
        tmw_pkg::OP_PUT_CELL: begin
          exec_we   = pos_ok;
          exec_addr = tmw_pkg::cell_addr(px_r, py_r);
          exec_data = {color_r, ch_r};
        end
        tmw_pkg::OP_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        tmw_pkg::OP_READ_CELL: begin
          rd_hit_nxt = pos_ok;
        end
        default: begin
          col_nxt = cur_col_r;
        end
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = {attr_r, tmw_pkg::CH_SPACE};
    if (cmd.init_wr) begin
      we    = 1'b1;
      wdata = {tmw_pkg::RESET_ATTR, tmw_pkg::CH_SPACE};
    end else if (cmd.fill_wr) begin
      we = 1'b1;
    end else if (cmd.copy_wr) begin
      we    = 1'b1;
      wdata = rdata_r;
    end else if (cmd.exec) begin
      we    = exec_we;
      waddr = exec_addr;
      wdata = exec_data;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = tmw_pkg::cell_addr(px_r, py_r);
    if (cmd.copy_rd) begin
      re    = 1'b1;
      raddr = ADDR_W'(int'(idx_r) + tmw_pkg::COLUMNS);
    end else if (cmd.exec && op_r == tmw_pkg::OP_READ_CELL) begin
      re = pos_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r    <= in_operation;
      ch_r    <= in_char_code;
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      color_r <= in_cell_color;
    end
    if (cmd.out_load) begin
      out_col_r    <= 7'(col_nxt);
      out_row_r    <= 5'(row_nxt);
      out_lin_r    <= tmw_pkg::lin11(row_nxt, col_nxt);
      out_scroll_r <= scroll_nxt;
      out_char_r   <= rd_hit_r ? rdata_r[7:0] : 8'h00;
      out_attr_r   <= rd_hit_r ? rdata_r[15:8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= tmw_pkg::RESET_ATTR;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      idx_r       <= '0;
      scroll_r    <= 1'b0;
      rd_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      cur_col_r <= col_nxt;
      cur_row_r <= row_nxt;
      if (cmd.load_item) begin
        scroll_r <= 1'b0;
        rd_hit_r <= 1'b0;
      end else begin
        scroll_r <= scroll_nxt;
        rd_hit_r <= rd_hit_nxt;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_blank) begin
        idx_r <= ADDR_W'(tmw_pkg::SCROLL_CELLS);
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + ADDR_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.op          = op_r;
  assign stat.scroll_need = scroll_need;
  assign stat.idx_last    = (idx_r == ADDR_W'(tmw_pkg::CELL_COUNT - 1));
  assign stat.copy_last   = (idx_r == ADDR_W'(tmw_pkg::SCROLL_CELLS - 1));
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_linear = out_lin_r;
  assign out_did_scroll    = out_scroll_r;
  assign out_read_char     = out_char_r;
  assign out_read_attr     = out_attr_r;

endmodule

>>> rtl/text_mode_terminal_writer.sv
// Text-mode terminal writer top level; uses tmw_pkg, tmw_in_if, tmw_out_if.
// Put character, set cursor and put at cell go from the execute state to the result register;
// read cell waits for the store read; clear blanks all cells; a scroll also moves the rows up.
// One item is in work at a time, so the next transfer waits until the last item is through.
// A result waits in an output register while the next item is taken.
// After reset the store is filled with blank cells with in ready low.
module text_mode_terminal_writer (
  input  logic        clk,
  input  logic        rst_n,
  tmw_in_if.sink      in_if,
  tmw_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  tmw_pkg::tmw_cmd_t  cmd;
  tmw_pkg::tmw_stat_t stat;

  tmw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tmw_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_if.operation),
    .in_char_code      (in_if.char_code),
    .in_pos_x          (in_if.pos_x),
    .in_pos_y          (in_if.pos_y),
    .in_cell_color     (in_if.cell_color),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_cursor_col    (out_if.cursor_col),
    .out_cursor_row    (out_if.cursor_row),
    .out_cursor_linear (out_if.cursor_linear),
    .out_did_scroll    (out_if.did_scroll),
    .out_read_char     (out_if.read_char),
    .out_read_attr     (out_if.read_attr),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

>>> rtl/tmw_checker.sv
// Port-level checker for the terminal writer and its bind to the top level.
// Uses tmw_pkg for the screen geometry.
module tmw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  cursor_col,
  input logic [4:0]  cursor_row,
  input logic [10:0] cursor_linear,
  input logic        did_scroll,
  input logic [7:0]  read_char,
  input logic [7:0]  read_attr
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_col) && $stable(cursor_row)
      && $stable(cursor_linear) && $stable(did_scroll) && $stable(read_char)
      && $stable(read_attr))
    else $error("Result changed while stalled.");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(cursor_col) < tmw_pkg::COLUMNS) && (int'(cursor_row) < tmw_pkg::ROWS))
    else $error("Cursor out of range.");

  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && did_scroll |-> cursor_col == 7'd0
      && cursor_row == 5'(tmw_pkg::ROWS - 1))
    else $error("Scroll left the cursor off the start of the last row.");

endmodule

bind text_mode_terminal_writer tmw_checker u_tmw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .cursor_col    (out_if.cursor_col),
  .cursor_row    (out_if.cursor_row),
  .cursor_linear (out_if.cursor_linear),
  .did_scroll    (out_if.did_scroll),
  .read_char     (out_if.read_char),
  .read_attr     (out_if.read_attr)
);

>>> test/tb_text_mode_terminal_writer.sv
`timescale 1ns / 100ps
// Testbench for text_mode_terminal_writer: a directed table, then random command phases.
// Results are checked against the table or a predictor of the screen store and cursor.
// Depends on tmw_pkg, tmw_in_if, tmw_out_if and the block itself.
module tb_text_mode_terminal_writer;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam int SCRIPT_LEN   = 26;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int DRAIN_LIMIT  = 200000;
  localparam int SCROLL_LAT   = 2 * tmw_pkg::COLUMNS * (tmw_pkg::ROWS - 1)
                                + tmw_pkg::COLUMNS + 3;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [6:0] x;
    logic [5:0] y;
    logic [7:0] color;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] lin;
    logic        scr;
    logic [7:0]  rch;
    logic [7:0]  rattr;
  } res_t;

  typedef struct packed {
    cmd_t cmd;
    logic known;
    res_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  tmw_in_if  cmd_ch();
  tmw_out_if res_ch();

  text_mode_terminal_writer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (cmd_ch),
    .out_if   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  tmw_pkg::cell_t screen [tmw_pkg::CELL_COUNT];
  logic [6:0] cur_col;
  logic [4:0] cur_row;
  logic [7:0] text_attr;
  res_t       due_results [$];

  int idle_pct;
  int stall_pct;
  int fails;
  int n_sent;
  int n_seen;
  int n_scrolls;
  int n_reads;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #100_000_000;
    $display("Simulation time limit reached with %0d results outstanding.",
             due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void blank_from(int first, logic [7:0] attr);
    for (int i = first; i < tmw_pkg::CELL_COUNT; i++) screen[i] = {attr, tmw_pkg::CH_SPACE};
  endfunction

  function automatic res_t terminal_step(cmd_t c);
    res_t r;
    int idx;
    r = '0;
    case (c.op)
      tmw_pkg::OP_PUT_CHAR: begin
        if (c.ch == tmw_pkg::CH_LF) begin
          cur_col = '0;
          cur_row++;
        end else if (c.ch == tmw_pkg::CH_CR) begin
          cur_col = '0;
        end else if (c.ch == tmw_pkg::CH_TAB) begin
          cur_col = (cur_col + 7'd8) & ~7'd7;
          if (cur_col >= tmw_pkg::COLUMNS) begin
            cur_col = '0;
            cur_row++;
          end
        end else if (c.ch == tmw_pkg::CH_BS) begin
          if (cur_col > 0) begin
            cur_col--;
            screen[int'(cur_row) * tmw_pkg::COLUMNS + int'(cur_col)] =
              {text_attr, tmw_pkg::CH_SPACE};
          end
        end else if (c.ch >= tmw_pkg::CH_SPACE) begin
          screen[int'(cur_row) * tmw_pkg::COLUMNS + int'(cur_col)] = {text_attr, c.ch};
          cur_col++;
          if (cur_col >= tmw_pkg::COLUMNS) begin
            cur_col = '0;
            cur_row++;
          end
        end
        if (cur_row >= tmw_pkg::ROWS) begin
          for (int i = 0; i < tmw_pkg::SCROLL_CELLS; i++) begin
            screen[i] = screen[i + tmw_pkg::COLUMNS];
          end
          blank_from(tmw_pkg::SCROLL_CELLS, text_attr);
          cur_row = 5'(tmw_pkg::ROWS - 1);
          r.scr = 1'b1;
        end
      end
      tmw_pkg::OP_SET_CURSOR: begin
        if (c.x < tmw_pkg::COLUMNS) cur_col = c.x;
        if (c.y < tmw_pkg::ROWS) cur_row = 5'(c.y);
      end
      tmw_pkg::OP_PUT_CELL: begin
        if (c.x < tmw_pkg::COLUMNS && c.y < tmw_pkg::ROWS) begin
          screen[int'(c.y) * tmw_pkg::COLUMNS + int'(c.x)] = {c.color, c.ch};
        end
      end
      tmw_pkg::OP_CLEAR: begin
        blank_from(0, text_attr);
        cur_col = '0;
        cur_row = '0;
      end
      tmw_pkg::OP_READ_CELL: begin
        if (c.x < tmw_pkg::COLUMNS && c.y < tmw_pkg::ROWS) begin
          idx = int'(c.y) * tmw_pkg::COLUMNS + int'(c.x);
          {r.rattr, r.rch} = screen[idx];
        end
      end
      default: ;
    endcase
    r.col = cur_col;
    r.row = cur_row;
    r.lin = 11'(int'(cur_row) * tmw_pkg::COLUMNS + int'(cur_col));
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    int k;
    c.op    = tmw_pkg::OP_PUT_CHAR;
    c.ch    = 8'($urandom_range(255));
    c.x     = 7'($urandom_range(127));
    c.y     = 6'($urandom_range(63));
    c.color = 8'($urandom_range(255));
    pick = $urandom_range(99);
    k    = $urandom_range(99);
    if (pick < 50) begin
      if (k < 8) c.ch = tmw_pkg::CH_LF;
      else if (k < 12) c.ch = tmw_pkg::CH_CR;
      else if (k < 17) c.ch = tmw_pkg::CH_TAB;
      else if (k < 23) c.ch = tmw_pkg::CH_BS;
      else if (k < 27) c.ch = 8'($urandom_range(31));
      else c.ch = 8'($urandom_range(255, 32));
    end else if (pick < 64) begin
      c.op = tmw_pkg::OP_SET_CURSOR;
      if (k < 25) begin
        c.x = 7'($urandom_range(tmw_pkg::COLUMNS - 1));
        c.y = 6'(tmw_pkg::ROWS - 1);
      end else if (k < 85) begin
        c.x = 7'($urandom_range(tmw_pkg::COLUMNS - 1));
        c.y = 6'($urandom_range(tmw_pkg::ROWS - 1));
      end
    end else if (pick < 94) begin
      c.op = (pick < 78) ? tmw_pkg::OP_PUT_CELL : tmw_pkg::OP_READ_CELL;
      if (k < 85) begin
        c.x = 7'($urandom_range(tmw_pkg::COLUMNS - 1));
        c.y = 6'($urandom_range(tmw_pkg::ROWS - 1));
      end
    end else if (pick < 96) begin
      c.op = tmw_pkg::OP_CLEAR;
    end else begin
      c.op = 3'($urandom_range(OP_SPARE_C, OP_SPARE_A));
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(input cmd_t c, input logic known, input res_t typed);
    res_t pred;
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= c.op;
    cmd_ch.char_code  <= c.ch;
    cmd_ch.pos_x      <= c.x;
    cmd_ch.pos_y      <= c.y;
    cmd_ch.cell_color <= c.color;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    pred = terminal_step(c);
    due_results.push_back(known ? typed : pred);
    n_sent++;
    if (c.op == tmw_pkg::OP_READ_CELL) n_reads++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    cmd_ch.valid <= 1'b0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_results.size() != 0) begin
      fails++;
      $display("Results still outstanding after %0d cycles: %0d", waited,
               due_results.size());
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    text_attr = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.cursor_col, res_ch.cursor_row, res_ch.cursor_linear,
              res_ch.did_scroll, res_ch.read_char, res_ch.read_attr};
      n_seen++;
      if (got.scr) n_scrolls++;
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= 10) $display("%t: result transfer with nothing expected", $realtime);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10) begin
            $display("%t: result %0d mismatch (col,row,linear,scroll,char,attr)",
                     $realtime, n_seen);
            $display("  expected %0d %0d %0d %0d %02h %02h", want.col, want.row,
                     want.lin, want.scr, want.rch, want.rattr);
            $display("  actual   %0d %0d %0d %0d %02h %02h", got.col, got.row,
                     got.lin, got.scr, got.rch, got.rattr);
          end
        end
      end
    end
  end

  initial begin
    row_t script [SCRIPT_LEN];
    logic [7:0] attr;
    int n_attrs;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.operation  = tmw_pkg::OP_PUT_CHAR;
    cmd_ch.char_code  = '0;
    cmd_ch.pos_x      = '0;
    cmd_ch.pos_y      = '0;
    cmd_ch.cell_color = '0;
    idle_pct  = 0;
    stall_pct = 0;
    fails     = 0;
    n_sent    = 0;
    n_seen    = 0;
    n_scrolls = 0;
    n_reads   = 0;
    n_attrs   = 1;
    text_attr = tmw_pkg::RESET_ATTR;
    cur_col   = '0;
    cur_row   = '0;
    blank_from(0, tmw_pkg::RESET_ATTR);

    script = '{
      '{'{tmw_pkg::OP_READ_CELL, 8'h00, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd0, 5'd0, 11'd0, 1'b0, tmw_pkg::CH_SPACE, tmw_pkg::RESET_ATTR}},
      '{'{tmw_pkg::OP_READ_CELL, 8'h00, 7'd79, 6'd24, 8'h00}, 1'b1,
        '{7'd0, 5'd0, 11'd0, 1'b0, tmw_pkg::CH_SPACE, tmw_pkg::RESET_ATTR}},
      '{'{tmw_pkg::OP_READ_CELL, 8'hFF, 7'd127, 6'd63, 8'hFF}, 1'b1,
        '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CHAR, 8'h41, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd1, 5'd0, 11'd1, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CHAR, 8'hFF, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd2, 5'd0, 11'd2, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CHAR, 8'h1F, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd2, 5'd0, 11'd2, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CHAR, tmw_pkg::CH_BS, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd1, 5'd0, 11'd1, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_READ_CELL, 8'h00, 7'd1, 6'd0, 8'h00}, 1'b1,
        '{7'd1, 5'd0, 11'd1, 1'b0, tmw_pkg::CH_SPACE, tmw_pkg::RESET_ATTR}},
      '{'{tmw_pkg::OP_PUT_CHAR, tmw_pkg::CH_TAB, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd8, 5'd0, 11'd8, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CHAR, tmw_pkg::CH_CR, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_SET_CURSOR, 8'h00, 7'd127, 6'd63, 8'h00}, 1'b1,
        '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_SET_CURSOR, 8'h00, 7'd79, 6'd63, 8'h00}, 1'b1,
        '{7'd79, 5'd0, 11'd79, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CHAR, tmw_pkg::CH_SPACE, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd0, 5'd1, 11'd80, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_SET_CURSOR, 8'h00, 7'd72, 6'd24, 8'h00}, 1'b1,
        '{7'd72, 5'd24, 11'd1992, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CHAR, tmw_pkg::CH_TAB, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd0, 5'd24, 11'd1920, 1'b1, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_SET_CURSOR, 8'h00, 7'd79, 6'd63, 8'h00}, 1'b1,
        '{7'd79, 5'd24, 11'd1999, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CHAR, 8'h7E, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd0, 5'd24, 11'd1920, 1'b1, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CHAR, tmw_pkg::CH_LF, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd0, 5'd24, 11'd1920, 1'b1, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CELL, 8'h5A, 7'd79, 6'd24, 8'hFF}, 1'b1,
        '{7'd0, 5'd24, 11'd1920, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_PUT_CELL, 8'h00, 7'd127, 6'd63, 8'h00}, 1'b0, '0},
      '{'{tmw_pkg::OP_READ_CELL, 8'h00, 7'd79, 6'd24, 8'h00}, 1'b1,
        '{7'd0, 5'd24, 11'd1920, 1'b0, 8'h5A, 8'hFF}},
      '{'{tmw_pkg::OP_READ_CELL, 8'h00, 7'd0, 6'd0, 8'h00}, 1'b0, '0},
      '{'{tmw_pkg::OP_PUT_CHAR, tmw_pkg::CH_BS, 7'd0, 6'd0, 8'h00}, 1'b0, '0},
      '{'{OP_SPARE_C, 8'hFF, 7'd127, 6'd63, 8'hFF}, 1'b0, '0},
      '{'{tmw_pkg::OP_CLEAR, 8'h00, 7'd0, 6'd0, 8'h00}, 1'b1,
        '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      '{'{tmw_pkg::OP_READ_CELL, 8'h00, 7'd0, 6'd24, 8'h00}, 1'b1,
        '{7'd0, 5'd0, 11'd0, 1'b0, tmw_pkg::CH_SPACE, tmw_pkg::RESET_ATTR}}
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) send_cmd(script[i].cmd, script[i].known, script[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p == 0) attr = 8'h00;
      else if (p == 1) attr = 8'hFF;
      else attr = 8'($urandom_range(255));
      write_attr(attr);
      n_attrs++;
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd(), 1'b0, '0);
    end

    drain_results();
    repeat (SCROLL_LAT) @(posedge clk);

    $display("Sent %0d commands (%0d from the directed table) under %0d attribute settings.",
             n_sent, SCRIPT_LEN, n_attrs);
    $display("Checked %0d results: %0d scrolled the screen, %0d were cell reads; %0d failures.",
             n_seen, n_scrolls, n_reads, fails);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tmw_pkg.sv
rtl/tmw_in_if.sv
rtl/tmw_out_if.sv
rtl/tmw_ctrl.sv
rtl/tmw_dp.sv
rtl/text_mode_terminal_writer.sv
rtl/tmw_checker.sv
test/tb_text_mode_terminal_writer.sv
